### sv/bitmap_slot_allocator_defines.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BSA_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BSA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bsa_pkg.sv
// Package for the slot allocator: defaults, operation codes and sequencer states.
`timescale 1ns / 1ps
package bsa_pkg;

  // Default pool geometry.
  localparam int POOL_DEPTH_DEF = 256;
  localparam int WORD_BITS_DEF  = 32;

  // Reset value of the pool size register.
  localparam logic [8:0] POOL_SIZE_RESET = 9'd256;

  // Single-bit mask seed used when setting a free bit.
  localparam logic ONE_BIT = 1'b1;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

### sv/bitmap_slot_allocator.sv
// Top level of the first-fit slot allocator over a free bitmap.
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_defines.svh"
// A word is taken when start is high and busy is low; each word is either an
// allocate, which claims the lowest free slot below the pool size, or a free,
// which returns one slot. After reset the block sweeps the bitmap memory to all
// ones, one word a cycle, with busy high throughout. A request is then served by
// walking the bitmap memory one word per cycle through its single read port: an
// allocate stays busy up to and including the word holding the grant (at most
// ceil(size / WORD_BITS) words, 8 at the defaults), a free up to and including
// the word holding its slot, and a request that is refused at once (empty pool,
// index out of range) does not raise busy. The result appears on success and
// granted_index, marked by done, which is high for a single cycle in the cycle
// after the last busy cycle; it cannot be held off, so it must be captured then.
// A new request may be started in that same cycle.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pool_size_we,
  input  logic [8:0] pool_size_wdata,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] slot_index,
  output logic       done,
  output logic       success,
  output logic [7:0] granted_index
);

  localparam int NUM_WORDS = (POOL_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
  localparam int WB_W      = $clog2(WORD_BITS + 1);
  localparam int CMP_W0    = (CNT_W > 9) ? CNT_W : 9;
  localparam int CMP_W     = (CMP_W0 > WB_W) ? CMP_W0 : WB_W;

  // Registers, and the next state of the sequencer.
  state_t               state;
  state_t               state_next;
  logic [8:0]           pool_size;
  logic [ADDR_W-1:0]    word_idx;
  logic [CMP_W-1:0]     slot_base;
  logic [CMP_W-1:0]     remain;
  logic [7:0]           offset;
  logic                 op_reg;

  // Combinational signals.
  logic [CMP_W-1:0]     size_eff;
  logic                 accept;
  logic                 reject_now;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] lowest;
  logic                 found;
  logic [BIT_W-1:0]     enc;
  logic                 last_word;
  logic                 hit_free;
  logic [CMP_W-1:0]     grant_slot;
  logic                 finish;
  logic                 res_ok;
  logic [7:0]           res_grant;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;

  // Bitmap store, one bit per slot, a one meaning free.
  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Effective pool size and request checks.
  always_comb begin
    if (CMP_W'(pool_size) > CMP_W'(POOL_DEPTH)) begin
      size_eff = CMP_W'(POOL_DEPTH);
    end else begin
      size_eff = CMP_W'(pool_size);
    end
    accept = start && !busy;
    if (operation == OP_ALLOC) begin
      reject_now = (size_eff == '0);
    end else begin
      reject_now = !(CMP_W'(slot_index) < size_eff);
    end
  end

  // Search of the current word: mask slots beyond the pool, isolate the lowest free bit.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      valid_mask[b] = (CMP_W'(b) < remain);
    end
    cand   = rd_data & valid_mask;
    lowest = cand & (~cand + WORD_BITS'(1));
    found  = |cand;
    enc    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        enc = enc | BIT_W'(b);
      end
    end
    last_word  = (remain <= CMP_W'(WORD_BITS));
    hit_free   = (CMP_W'(offset) < CMP_W'(WORD_BITS));
    grant_slot = slot_base + CMP_W'(enc);
  end

  // Sequencer outputs: memory controls and the result of this cycle.
  always_comb begin
    busy      = (state != ST_IDLE);
    finish    = 1'b0;
    res_ok    = 1'b0;
    res_grant = '0;
    ram_we    = 1'b0;
    ram_waddr = word_idx;
    ram_wdata = '1;
    ram_raddr = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && reject_now) begin
          finish = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_raddr = word_idx + ADDR_W'(1);
        if (op_reg == OP_ALLOC) begin
          ram_wdata = rd_data & ~lowest;
          if (found) begin
            ram_we    = 1'b1;
            finish    = 1'b1;
            res_ok    = 1'b1;
            res_grant = grant_slot[7:0];
          end else if (last_word) begin
            finish = 1'b1;
          end
        end else begin
          ram_wdata = rd_data | (WORD_BITS'(ONE_BIT) << offset[BIT_W-1:0]);
          if (hit_free) begin
            ram_we = 1'b1;
            finish = 1'b1;
            res_ok = 1'b1;
          end
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (word_idx == ADDR_W'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !reject_now) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      word_idx  <= '0;
      pool_size <= POOL_SIZE_RESET;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (pool_size_we) begin
        pool_size <= pool_size_wdata;
      end
      if (state == ST_CLEAR) begin
        word_idx <= word_idx + ADDR_W'(1);
      end else if (state == ST_IDLE) begin
        word_idx <= '0;
      end else if (!finish) begin
        word_idx <= word_idx + ADDR_W'(1);
      end
    end
  end

  // Scan position and result registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      slot_base <= '0;
      remain    <= size_eff;
      offset    <= slot_index;
      op_reg    <= operation;
    end else if (state == ST_SCAN) begin
      slot_base <= slot_base + CMP_W'(WORD_BITS);
      remain    <= remain - CMP_W'(WORD_BITS);
      offset    <= offset - 8'(WORD_BITS);
    end
    if (finish) begin
      success       <= res_ok;
      granted_index <= res_grant;
    end
  end

  // Checks on the sequencer.
  `BSA_CHECK(a_scan_has_slots, state == ST_SCAN, remain != '0, "scan with no slots left")
  `BSA_CHECK_NEXT(a_accept_progress, accept, done || busy, "accepted word not served")
  `BSA_CHECK(a_grant_zero, done && (!success || op_reg == OP_FREE), ~|granted_index, "stray grant")

endmodule

### sv/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
